// ===== hdl/scc_pkg.sv =====
// Shared types and constants for the strongly connected components block.
// Holds the controller states, datapath commands and the status struct.
// Depends on nothing.
package scc_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF    = 256;
	localparam int VTX_W            = 6;
	localparam int CFG_W            = 7;
	localparam int PADDR_W          = 2;
	localparam int PDATA_W          = 32;
	localparam logic [PADDR_W-1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic ACT_LOAD = 1'b0;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_ROOT1,
		ST_SCAN,
		ST_CHECK,
		ST_POP,
		ST_POPLD,
		ST_P2START,
		ST_ROOT2A,
		ST_ROOT2B,
		ST_FLUSHRD,
		ST_FLUSHWR,
		ST_EMITRD,
		ST_EMITWR
	} state_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_START,
		OP_ROOT1,
		OP_SCAN,
		OP_CHECK,
		OP_POP,
		OP_POPLD,
		OP_P2START,
		OP_ROOT2A,
		OP_ROOT2B,
		OP_FLUSHRD,
		OP_FLUSHWR,
		OP_EMITRD,
		OP_EMITWR
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic scan_end;
		logic push;
		logic skip;
		logic sp_last;
		logic second;
		logic root_end;
		logic root_vis;
		logic fin_zero;
		logic root_skip;
		logic flush_end;
		logic out_free;
		logic emit_last;
	} status_t;

endpackage

// ===== hdl/scc_ctrl.sv =====
// Controller state machine for the component search.
// Sequences both walks, the label flush and the result emit; uses scc_pkg.
// Drives datapath commands and reads back its status.
module scc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             action,
	output logic             item_stall,
	input  scc_pkg::status_t stat,
	output scc_pkg::cmd_t    cmd
);

	scc_pkg::state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			scc_pkg::ST_IDLE: begin
				if (item_valid && action != scc_pkg::ACT_LOAD) state_nx = scc_pkg::ST_START;
			end
			scc_pkg::ST_START:   state_nx = scc_pkg::ST_ROOT1;
			scc_pkg::ST_ROOT1: begin
				if (stat.root_end)      state_nx = scc_pkg::ST_P2START;
				else if (!stat.root_vis) state_nx = scc_pkg::ST_SCAN;
			end
			scc_pkg::ST_SCAN:
				state_nx = stat.scan_end ? scc_pkg::ST_POP : scc_pkg::ST_CHECK;
			scc_pkg::ST_CHECK: begin
				if (stat.push || stat.skip) state_nx = scc_pkg::ST_SCAN;
				else                        state_nx = scc_pkg::ST_POP;
			end
			scc_pkg::ST_POP: begin
				if (!stat.sp_last)    state_nx = scc_pkg::ST_POPLD;
				else if (stat.second) state_nx = scc_pkg::ST_FLUSHRD;
				else                  state_nx = scc_pkg::ST_ROOT1;
			end
			scc_pkg::ST_POPLD:   state_nx = scc_pkg::ST_SCAN;
			scc_pkg::ST_P2START: state_nx = scc_pkg::ST_ROOT2A;
			scc_pkg::ST_ROOT2A:
				state_nx = stat.fin_zero ? scc_pkg::ST_EMITRD : scc_pkg::ST_ROOT2B;
			scc_pkg::ST_ROOT2B:
				state_nx = stat.root_skip ? scc_pkg::ST_ROOT2A : scc_pkg::ST_SCAN;
			scc_pkg::ST_FLUSHRD:
				state_nx = stat.flush_end ? scc_pkg::ST_ROOT2A : scc_pkg::ST_FLUSHWR;
			scc_pkg::ST_FLUSHWR: state_nx = scc_pkg::ST_FLUSHRD;
			scc_pkg::ST_EMITRD:  state_nx = scc_pkg::ST_EMITWR;
			scc_pkg::ST_EMITWR: begin
				if (stat.out_free)
					state_nx = stat.emit_last ? scc_pkg::ST_IDLE : scc_pkg::ST_EMITRD;
			end
			default: state_nx = scc_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd.op     = scc_pkg::OP_NONE;
		item_stall = 1'b1;
		unique case (state_q)
			scc_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid)
					cmd.op = (action == scc_pkg::ACT_LOAD) ? scc_pkg::OP_LOAD
					                                       : scc_pkg::OP_START;
			end
			scc_pkg::ST_START:   cmd.op = scc_pkg::OP_NONE;
			scc_pkg::ST_ROOT1:   cmd.op = scc_pkg::OP_ROOT1;
			scc_pkg::ST_SCAN:    cmd.op = scc_pkg::OP_SCAN;
			scc_pkg::ST_CHECK:   cmd.op = scc_pkg::OP_CHECK;
			scc_pkg::ST_POP:     cmd.op = scc_pkg::OP_POP;
			scc_pkg::ST_POPLD:   cmd.op = scc_pkg::OP_POPLD;
			scc_pkg::ST_P2START: cmd.op = scc_pkg::OP_P2START;
			scc_pkg::ST_ROOT2A:  cmd.op = scc_pkg::OP_ROOT2A;
			scc_pkg::ST_ROOT2B:  cmd.op = scc_pkg::OP_ROOT2B;
			scc_pkg::ST_FLUSHRD: cmd.op = scc_pkg::OP_FLUSHRD;
			scc_pkg::ST_FLUSHWR: cmd.op = scc_pkg::OP_FLUSHWR;
			scc_pkg::ST_EMITRD:  cmd.op = scc_pkg::OP_EMITRD;
			scc_pkg::ST_EMITWR:  cmd.op = scc_pkg::OP_EMITWR;
			default:             cmd.op = scc_pkg::OP_NONE;
		endcase
	end

endmodule

// ===== hdl/scc_dp.sv =====
// Datapath for the component search: edge store, walk stack, finish order,
// member list, label table, visited bits and the result register.
// Uses scc_pkg; driven by scc_ctrl commands.
module scc_dp #(
	parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = scc_pkg::MAX_EDGES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  scc_pkg::cmd_t             cmd,
	output scc_pkg::status_t          stat,
	input  logic [scc_pkg::CFG_W-1:0] vertex_count,
	input  logic [scc_pkg::VTX_W-1:0] from_vertex,
	input  logic [scc_pkg::VTX_W-1:0] to_vertex,
	input  logic                      result_stall,
	output logic                      result_valid,
	output logic [scc_pkg::VTX_W-1:0] vertex_index,
	output logic [scc_pkg::VTX_W-1:0] component_label,
	output logic                      last_vertex,
	output logic                      edges_dropped
);

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int CW  = $clog2(MAX_VERTICES + 1);
	localparam int EW  = $clog2(MAX_EDGES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int FW  = VW + EW;

	// memories
	logic [VW-1:0] esrc_mem [MAX_EDGES];
	logic [VW-1:0] edst_mem [MAX_EDGES];
	logic [FW-1:0] stack_mem [MAX_VERTICES];
	logic [VW-1:0] fin_mem [MAX_VERTICES];
	logic [VW-1:0] memb_mem [MAX_VERTICES];
	logic [VW-1:0] comp_mem [MAX_VERTICES];

	// control registers
	logic [EW-1:0]           edge_total_q;
	logic                    drop_q;
	logic [MAX_VERTICES-1:0] vis_q;
	logic [CW-1:0]           sp_q, fin_q, cnt_q, i_q, j_q;
	logic                    second_q;
	logic                    out_valid_q;

	// payload registers
	logic [VW-1:0] top_v_q, low_q;
	logic [EW-1:0] top_k_q;
	logic [VW-1:0] src_rd_q, dst_rd_q, fin_rd_q, memb_rd_q, comp_rd_q;
	logic [FW-1:0] stack_rd_q;
	logic [scc_pkg::VTX_W-1:0] vidx_q, label_q;
	logic last_q, dropped_q;

	logic [CW-1:0] n;
	logic [CW-1:0] sp_m1, sp_m2, fin_m1;
	logic [VW-1:0] self_v, nb_v;
	logic          range_ok, match, room, load_ok;

	// vertex count clamped to 1..MAX_VERTICES
	always_comb begin
		if (vertex_count == '0)
			n = CW'(1);
		else if (vertex_count > scc_pkg::CFG_W'(MAX_VERTICES))
			n = CW'(MAX_VERTICES);
		else
			n = CW'(vertex_count);
	end

	assign sp_m1  = sp_q - CW'(1);
	assign sp_m2  = sp_q - CW'(2);
	assign fin_m1 = fin_q - CW'(1);

	// edge test: forward uses source/target, transposed swaps them
	always_comb begin
		range_ok = (CW'(src_rd_q) < n) && (CW'(dst_rd_q) < n);
		self_v   = second_q ? dst_rd_q : src_rd_q;
		nb_v     = second_q ? src_rd_q : dst_rd_q;
		match    = range_ok && (self_v == top_v_q) && !vis_q[nb_v];
		room     = (sp_q < CW'(MAX_VERTICES)) &&
		           (!second_q || cnt_q < CW'(MAX_VERTICES));
		load_ok  = (7'(from_vertex) < 7'(n)) && (7'(to_vertex) < 7'(n)) &&
		           (edge_total_q < EW'(MAX_EDGES));
	end

	// status back to the controller
	always_comb begin
		stat.scan_end  = top_k_q >= edge_total_q;
		stat.push      = match && room;
		stat.skip      = !match;
		stat.sp_last   = sp_q == CW'(1);
		stat.second    = second_q;
		stat.root_end  = i_q == n;
		stat.root_vis  = vis_q[i_q[VW-1:0]];
		stat.fin_zero  = fin_q == '0;
		stat.root_skip = (CW'(fin_rd_q) >= n) || vis_q[fin_rd_q];
		stat.flush_end = j_q == cnt_q;
		stat.out_free  = !out_valid_q || !result_stall;
		stat.emit_last = i_q == (n - CW'(1));
	end

	// edge store
	always_ff @(posedge clk) begin
		if (cmd.op == scc_pkg::OP_LOAD && load_ok) begin
			esrc_mem[edge_total_q[EAW-1:0]] <= from_vertex[VW-1:0];
			edst_mem[edge_total_q[EAW-1:0]] <= to_vertex[VW-1:0];
		end
		if (cmd.op == scc_pkg::OP_SCAN) begin
			src_rd_q <= esrc_mem[top_k_q[EAW-1:0]];
			dst_rd_q <= edst_mem[top_k_q[EAW-1:0]];
		end
	end

	// walk stack: holds the frames below the top one
	always_ff @(posedge clk) begin
		if (cmd.op == scc_pkg::OP_CHECK && match && room)
			stack_mem[sp_m1[VW-1:0]] <= {top_v_q, top_k_q + EW'(1)};
		if (cmd.op == scc_pkg::OP_POP)
			stack_rd_q <= stack_mem[sp_m2[VW-1:0]];
	end

	// finish order
	always_ff @(posedge clk) begin
		if (cmd.op == scc_pkg::OP_POP && !second_q && fin_q < CW'(MAX_VERTICES))
			fin_mem[fin_q[VW-1:0]] <= top_v_q;
		if (cmd.op == scc_pkg::OP_ROOT2A)
			fin_rd_q <= fin_mem[fin_m1[VW-1:0]];
	end

	// member list of the component being gathered
	always_ff @(posedge clk) begin
		if (cmd.op == scc_pkg::OP_ROOT2B && !stat.root_skip)
			memb_mem[0] <= fin_rd_q;
		else if (cmd.op == scc_pkg::OP_CHECK && match && room && second_q)
			memb_mem[cnt_q[VW-1:0]] <= nb_v;
		if (cmd.op == scc_pkg::OP_FLUSHRD)
			memb_rd_q <= memb_mem[j_q[VW-1:0]];
	end

	// component labels
	always_ff @(posedge clk) begin
		if (cmd.op == scc_pkg::OP_FLUSHWR)
			comp_mem[memb_rd_q] <= low_q;
		if (cmd.op == scc_pkg::OP_EMITRD)
			comp_rd_q <= comp_mem[i_q[VW-1:0]];
	end

	// walk state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q <= '0;
			drop_q       <= 1'b0;
			vis_q        <= '0;
			sp_q         <= '0;
			fin_q        <= '0;
			cnt_q        <= '0;
			i_q          <= '0;
			j_q          <= '0;
			second_q     <= 1'b0;
		end else begin
			unique case (cmd.op)
				scc_pkg::OP_LOAD: begin
					if (load_ok) edge_total_q <= edge_total_q + EW'(1);
					else         drop_q       <= 1'b1;
				end
				scc_pkg::OP_START: begin
					vis_q    <= '0;
					i_q      <= '0;
					fin_q    <= '0;
					sp_q     <= '0;
					second_q <= 1'b0;
				end
				scc_pkg::OP_ROOT1: begin
					if (!stat.root_end) begin
						i_q <= i_q + CW'(1);
						if (!stat.root_vis) begin
							vis_q[i_q[VW-1:0]] <= 1'b1;
							sp_q               <= CW'(1);
						end
					end
				end
				scc_pkg::OP_CHECK: begin
					if (match && room) begin
						vis_q[nb_v] <= 1'b1;
						sp_q        <= sp_q + CW'(1);
						if (second_q) cnt_q <= cnt_q + CW'(1);
					end
				end
				scc_pkg::OP_POP: begin
					sp_q <= sp_m1;
					if (!second_q && fin_q < CW'(MAX_VERTICES)) fin_q <= fin_q + CW'(1);
				end
				scc_pkg::OP_P2START: begin
					vis_q    <= '0;
					second_q <= 1'b1;
				end
				scc_pkg::OP_ROOT2A: begin
					if (fin_q == '0) i_q   <= '0;
					else             fin_q <= fin_m1;
				end
				scc_pkg::OP_ROOT2B: begin
					if (!stat.root_skip) begin
						vis_q[fin_rd_q] <= 1'b1;
						sp_q            <= CW'(1);
						cnt_q           <= CW'(1);
						j_q             <= '0;
					end
				end
				scc_pkg::OP_FLUSHWR: j_q <= j_q + CW'(1);
				scc_pkg::OP_EMITWR: begin
					if (stat.out_free) begin
						i_q <= i_q + CW'(1);
						if (stat.emit_last) begin
							edge_total_q <= '0;
							drop_q       <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// top frame and component minimum
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			scc_pkg::OP_ROOT1: begin
				top_v_q <= i_q[VW-1:0];
				top_k_q <= '0;
			end
			scc_pkg::OP_CHECK: begin
				if (match && room) begin
					top_v_q <= nb_v;
					top_k_q <= '0;
					if (nb_v < low_q) low_q <= nb_v;
				end else if (!match) begin
					top_k_q <= top_k_q + EW'(1);
				end
			end
			scc_pkg::OP_POPLD: {top_v_q, top_k_q} <= stack_rd_q;
			scc_pkg::OP_ROOT2B: begin
				top_v_q <= fin_rd_q;
				top_k_q <= '0;
				low_q   <= fin_rd_q;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == scc_pkg::OP_EMITWR && stat.out_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == scc_pkg::OP_EMITWR && stat.out_free) begin
			vidx_q    <= scc_pkg::VTX_W'(i_q);
			label_q   <= scc_pkg::VTX_W'(comp_rd_q);
			last_q    <= stat.emit_last;
			dropped_q <= drop_q;
		end
	end

	assign result_valid    = out_valid_q;
	assign vertex_index    = vidx_q;
	assign component_label = label_q;
	assign last_vertex     = last_q;
	assign edges_dropped   = dropped_q;

	// stack, finish list and edge count stay within their depth
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CW'(MAX_VERTICES))
		else $error("walk stack pointer beyond depth");

	a_fin_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q <= CW'(MAX_VERTICES))
		else $error("finish count beyond depth");

	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edge_total_q <= EW'(MAX_EDGES))
		else $error("edge count beyond store size");

	// a pushed vertex is marked visited once it is on top
	a_push_visits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == scc_pkg::OP_CHECK && match && room) |=> vis_q[top_v_q])
		else $error("pushed vertex not marked visited");

endmodule

// ===== hdl/strongly_connected_components.sv =====
// Strongly connected components (two depth-first walks, forward then transposed).
// Load item: accepted one per cycle while the block is idle. Run item: per walk
// each frame scans the single-ported edge store edge by edge; labels are then
// written for each component's members and emitted one vertex at a time.
// Reset (arst_n low, asynchronous) empties the edge store and drop flag and
// sets vertex_count to MAX_VERTICES; no clearing pass is needed.
module strongly_connected_components #(
	parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = scc_pkg::MAX_EDGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic                        action,
	input  logic [scc_pkg::VTX_W-1:0]   from_vertex,
	input  logic [scc_pkg::VTX_W-1:0]   to_vertex,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [scc_pkg::VTX_W-1:0]   vertex_index,
	output logic [scc_pkg::VTX_W-1:0]   component_label,
	output logic                        last_vertex,
	output logic                        edges_dropped,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [scc_pkg::PADDR_W-1:0] paddr,
	input  logic [scc_pkg::PDATA_W-1:0] pwdata,
	output logic [scc_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	scc_pkg::cmd_t    cmd;
	scc_pkg::status_t stat;
	logic [scc_pkg::CFG_W-1:0] vc_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= scc_pkg::CFG_W'(MAX_VERTICES);
		end else if (psel && penable && pwrite && pready &&
		             paddr == scc_pkg::REG_VERTEX_COUNT) begin
			vc_q <= pwdata[scc_pkg::CFG_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == scc_pkg::REG_VERTEX_COUNT) ?
	                scc_pkg::PDATA_W'(vc_q) : '0;

	scc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.action     (action),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	scc_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.vertex_count    (vc_q),
		.from_vertex     (from_vertex),
		.to_vertex       (to_vertex),
		.result_stall    (result_stall),
		.result_valid    (result_valid),
		.vertex_index    (vertex_index),
		.component_label (component_label),
		.last_vertex     (last_vertex),
		.edges_dropped   (edges_dropped)
	);

endmodule
